// ----- rtl/trlc_pkg.sv -----
// ============================================================================
// trlc_pkg: shared definitions for the two-road traffic light controller
// Widths, register map, reset durations and lamp encodings.
// ============================================================================
package trlc_pkg;

    // Countdown and duration width in ticks
    localparam int CNT_W = 14;

    // Number of roads driven by the controller
    localparam int NUM_ROADS = 2;

    // Configuration port geometry
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;

    // Register indexes (byte address is four times the index)
    localparam logic [REG_IDX_W-1:0] REG_RED   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_GREEN = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_AMBER = 2'd2;

    // Reset durations in ticks
    localparam logic [CNT_W-1:0] RED_TICKS_RST   = 14'd500;
    localparam logic [CNT_W-1:0] GREEN_TICKS_RST = 14'd300;
    localparam logic [CNT_W-1:0] AMBER_TICKS_RST = 14'd200;

    // Default tick rate of the seconds display
    localparam int TICKS_PER_SECOND_DEF = 100;

    // Lamp outputs: bit 0 red, bit 1 amber, bit 2 green
    localparam int LAMP_W = 3;
    localparam logic [LAMP_W-1:0] LAMP_RED   = 3'b001;
    localparam logic [LAMP_W-1:0] LAMP_AMBER = 3'b010;
    localparam logic [LAMP_W-1:0] LAMP_GREEN = 3'b100;
    localparam logic [LAMP_W-1:0] LAMP_OFF   = 3'b000;

    // Seconds display
    localparam int SEC_W  = 7;
    localparam int BCD_W  = 4;
    localparam logic [SEC_W-1:0] SEC_MAX = 7'd99;

endpackage

// ----- rtl/two_road_traffic_light_controller_top.sv -----
// ============================================================================
// two_road_traffic_light_controller_top
// Two independent red/green/amber road cycles stepped by tick transfers, with
// per-road lamps and remaining seconds shown as two BCD digits.
// ============================================================================
//
//  Channel  Direction  Handshake             Payload
//  -------  ---------  --------------------  ----------------------------------
//  in       sink       in_valid / in_stall   restart
//  out      source     out_valid / out_stall road0/1_lamps, road0/1_tens/units
//  apb      slave      psel/penable/pready   paddr, pwdata, prdata
//
//  One transfer is accepted per clock while in_stall is low; its result then
//  passes the stage registers in turn. The road state is updated in the accept cycle, the seconds quotient is
//  formed by a reciprocal multiply in the next stage, and the clamp and BCD
//  split fill the output register in the third.
//  A stalled output holds its result; earlier stages keep filling bubbles, so
//  the input stalls only when every stage holds an undelivered transfer.
//  Reset restores the default durations, road 0 red and road 1 green.
//
module two_road_traffic_light_controller_top #(
    parameter int TICKS_PER_SECOND = trlc_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,

    // Tick input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             restart,

    // Result channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [trlc_pkg::LAMP_W-1:0]      road0_lamps,
    output logic [trlc_pkg::LAMP_W-1:0]      road1_lamps,
    output logic [trlc_pkg::BCD_W-1:0]       road0_tens,
    output logic [trlc_pkg::BCD_W-1:0]       road0_units,
    output logic [trlc_pkg::BCD_W-1:0]       road1_tens,
    output logic [trlc_pkg::BCD_W-1:0]       road1_units,

    // Configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [trlc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [trlc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [trlc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    import trlc_pkg::*;

    // Road phase codes
    typedef enum logic [1:0] {
        PH_RED   = 2'd0,
        PH_AMBER = 2'd1,
        PH_GREEN = 2'd2
    } phase_t;

    // Reciprocal of the tick rate: q = (x * RECIP) >> RECIP_SHIFT is exact
    // for every countdown value because x * (RECIP * T - 2^S) < 2^S.
    localparam int RECIP_SHIFT = CNT_W + $clog2(TICKS_PER_SECOND);
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = CNT_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((2 ** RECIP_SHIFT) + TICKS_PER_SECOND - 1) / TICKS_PER_SECOND);

    // Constants of the BCD split: tens = (sec * 205) >> 11 for sec below 100
    localparam int DIV10_W = 15;
    localparam logic [DIV10_W-1:0] DIV10_MUL = 15'd205;
    localparam int DIV10_SHIFT = 11;

    // Configuration registers
    logic [CNT_W-1:0] red_ticks_reg;
    logic [CNT_W-1:0] green_ticks_reg;
    logic [CNT_W-1:0] amber_ticks_reg;

    // Road state (stage 0)
    phase_t           phase_reg [NUM_ROADS];
    logic [CNT_W-1:0] cnt_reg   [NUM_ROADS];
    phase_t           phase_next[NUM_ROADS];
    logic [CNT_W-1:0] cnt_next  [NUM_ROADS];
    logic [CNT_W-1:0] cnt_dec   [NUM_ROADS];
    logic             v0_reg;

    // Quotient stage (stage 1)
    phase_t           s1_phase_reg[NUM_ROADS];
    logic [CNT_W-1:0] s1_quot_reg [NUM_ROADS];
    logic             s1_zero_reg [NUM_ROADS];
    logic [PROD_W-1:0] quot_prod  [NUM_ROADS];
    logic             v1_reg;

    // Output stage (stage 2)
    logic [SEC_W-1:0]   sec      [NUM_ROADS];
    logic [DIV10_W-1:0] tens_prod[NUM_ROADS];
    logic [BCD_W-1:0]   tens     [NUM_ROADS];
    logic [BCD_W-1:0]   units    [NUM_ROADS];
    logic [LAMP_W-1:0]  lamps    [NUM_ROADS];
    logic [LAMP_W-1:0]  road0_lamps_reg;
    logic [LAMP_W-1:0]  road1_lamps_reg;
    logic [BCD_W-1:0]   road0_tens_reg;
    logic [BCD_W-1:0]   road0_units_reg;
    logic [BCD_W-1:0]   road1_tens_reg;
    logic [BCD_W-1:0]   road1_units_reg;
    logic               out_valid_reg;

    // Stage enables
    logic en_out;
    logic en1;
    logic en0;
    logic in_accept;

    // Register access decode
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    function automatic logic [LAMP_W-1:0] lamps_of(input phase_t ph);
        logic [LAMP_W-1:0] l;
        unique case (ph)
            PH_RED:   l = LAMP_RED;
            PH_AMBER: l = LAMP_AMBER;
            PH_GREEN: l = LAMP_GREEN;
            default:  l = LAMP_OFF;
        endcase
        return l;
    endfunction

    // A stage advances when it is empty or the stage after it advances.
    assign en_out    = !out_valid_reg || !out_stall;
    assign en1       = !v1_reg || en_out;
    assign en0       = !v0_reg || en1;
    assign in_stall  = !en0;
    assign in_accept = in_valid && en0;

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------

    assign pready  = 1'b1;
    assign cfg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    // Register writes; an address past the last register is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_ticks_reg   <= RED_TICKS_RST;
            green_ticks_reg <= GREEN_TICKS_RST;
            amber_ticks_reg <= AMBER_TICKS_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_RED:   red_ticks_reg   <= pwdata[CNT_W-1:0];
                REG_GREEN: green_ticks_reg <= pwdata[CNT_W-1:0];
                REG_AMBER: amber_ticks_reg <= pwdata[CNT_W-1:0];
                default:   ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (cfg_idx)
            REG_RED:   prdata = APB_DATA_W'(red_ticks_reg);
            REG_GREEN: prdata = APB_DATA_W'(green_ticks_reg);
            REG_AMBER: prdata = APB_DATA_W'(amber_ticks_reg);
            default:   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Stage 0: road countdowns and phases
    // ------------------------------------------------------------------------

    // Decrement each countdown; on expiry move to the next colour and reload.
    always_comb
    begin
        for (int r = 0; r < NUM_ROADS; r++)
        begin
            cnt_dec[r]    = (cnt_reg[r] == '0) ? '0 : cnt_reg[r] - CNT_W'(1);
            phase_next[r] = phase_reg[r];
            cnt_next[r]   = cnt_dec[r];
            if (cnt_dec[r] == '0)
            begin
                unique case (phase_reg[r])
                    PH_AMBER:
                    begin
                        phase_next[r] = PH_RED;
                        cnt_next[r]   = red_ticks_reg;
                    end
                    PH_GREEN:
                    begin
                        phase_next[r] = PH_AMBER;
                        cnt_next[r]   = amber_ticks_reg;
                    end
                    default:
                    begin
                        phase_next[r] = PH_GREEN;
                        cnt_next[r]   = green_ticks_reg;
                    end
                endcase
            end
        end
        // A restart puts both roads back to their starting phases.
        if (restart)
        begin
            phase_next[0] = PH_RED;
            cnt_next[0]   = red_ticks_reg;
            phase_next[1] = PH_GREEN;
            cnt_next[1]   = green_ticks_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg[0] <= PH_RED;
            cnt_reg[0]   <= RED_TICKS_RST;
            phase_reg[1] <= PH_GREEN;
            cnt_reg[1]   <= GREEN_TICKS_RST;
            v0_reg       <= 1'b0;
        end
        else if (en0)
        begin
            v0_reg <= in_valid;
            if (in_accept)
            begin
                for (int r = 0; r < NUM_ROADS; r++)
                begin
                    phase_reg[r] <= phase_next[r];
                    cnt_reg[r]   <= cnt_next[r];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: whole seconds left less one, (count - 1) / TICKS_PER_SECOND
    // ------------------------------------------------------------------------

    always_comb
    begin
        for (int r = 0; r < NUM_ROADS; r++)
        begin
            quot_prod[r] = PROD_W'(cnt_reg[r] - CNT_W'(1)) * PROD_W'(RECIP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en1)
        begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            for (int r = 0; r < NUM_ROADS; r++)
            begin
                s1_phase_reg[r] <= phase_reg[r];
                s1_quot_reg[r]  <= quot_prod[r][RECIP_SHIFT +: CNT_W];
                s1_zero_reg[r]  <= (cnt_reg[r] == '0);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: clamp to 99 seconds, split into BCD digits, drive lamps
    // ------------------------------------------------------------------------

    always_comb
    begin
        for (int r = 0; r < NUM_ROADS; r++)
        begin
            if (s1_zero_reg[r])
                sec[r] = '0;
            else if (s1_quot_reg[r] >= CNT_W'(SEC_MAX))
                sec[r] = SEC_MAX;
            else
                sec[r] = SEC_W'(s1_quot_reg[r]) + SEC_W'(1);
            tens_prod[r] = DIV10_W'(sec[r]) * DIV10_MUL;
            tens[r]      = tens_prod[r][DIV10_SHIFT +: BCD_W];
            units[r]     = BCD_W'(sec[r] - ({3'b000, tens[r]} << 3)
                                         - ({3'b000, tens[r]} << 1));
            lamps[r]     = lamps_of(s1_phase_reg[r]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en_out)
        begin
            out_valid_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            road0_lamps_reg <= lamps[0];
            road1_lamps_reg <= lamps[1];
            road0_tens_reg  <= tens[0];
            road0_units_reg <= units[0];
            road1_tens_reg  <= tens[1];
            road1_units_reg <= units[1];
        end
    end

    assign out_valid   = out_valid_reg;
    assign road0_lamps = road0_lamps_reg;
    assign road1_lamps = road1_lamps_reg;
    assign road0_tens  = road0_tens_reg;
    assign road0_units = road0_units_reg;
    assign road1_tens  = road1_tens_reg;
    assign road1_units = road1_units_reg;

`ifndef NO_ASSERTIONS
    // The input stalls only behind a full pipeline with a stalled result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && v1_reg && v0_reg))
        else $error("input stalled while the pipeline has room");

    // A running countdown above one drops by exactly one per tick.
    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !restart && cnt_reg[0] > CNT_W'(1))
        |=> (cnt_reg[0] == $past(cnt_reg[0]) - CNT_W'(1)))
        else $error("road 0 countdown did not decrement");

    // A restart puts road 0 on red and road 1 on green.
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && restart)
        |=> (phase_reg[0] == PH_RED && phase_reg[1] == PH_GREEN))
        else $error("restart did not restore the starting phases");

    // A new result appears only when the quotient stage held a transfer.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(v1_reg))
        else $error("result produced from an empty stage");

    // Displayed digits are always decimal.
    a_bcd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (road0_tens <= 4'd9 && road0_units <= 4'd9
                       && road1_tens <= 4'd9 && road1_units <= 4'd9))
        else $error("digit out of decimal range");
`endif

endmodule
